@@ hdl/bfsa_pkg.sv @@
// Shared types, codes and constants of the best-fit band allocator.
package bfsa_pkg;

    // Band table geometry
    localparam int MAX_BANDS = 16;
    localparam int IDX_W     = $clog2(MAX_BANDS);
    localparam int CNT_W     = $clog2(MAX_BANDS + 1);

    // Field widths
    localparam int POS_W  = 12;
    localparam int SIZE_W = 13;

    // Reset value of both atlas dimensions
    localparam logic [SIZE_W-1:0] ATLAS_RST = SIZE_W'(1024);

    // Operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_PLACE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_TALL  = 3'd1,
        ST_NO_FIT    = 3'd2,
        ST_FULL      = 3'd3,
        ST_GLYPH_OOR = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]        op;
        logic [SIZE_W-1:0] req_height;
        logic [POS_W-1:0]  band_pos;
        logic [SIZE_W-1:0] glyph_width;
    } t_in;

    typedef struct packed {
        logic [2:0]       status;
        logic [POS_W-1:0] slice_pos;
        logic [POS_W-1:0] glyph_x;
        logic [POS_W-1:0] glyph_y;
    } t_out;

    // One entry of the free band table
    typedef struct packed {
        logic [POS_W-1:0]  top;
        logic [SIZE_W-1:0] size;
    } t_band;

    // Shared adder operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_ADD1,
        ALU_SUB
    } t_alu_op;

    // Sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SHIFT,
        S_APPEND,
        S_FREE,
        S_PWRAP,
        S_PBUMP,
        S_PFIT,
        S_PCOMMIT,
        S_DONE
    } t_state;

    // Clamp a 14-bit sum to the 13-bit range
    function automatic logic [SIZE_W-1:0] sat13(input logic [SIZE_W:0] v);
        return v[SIZE_W] ? {SIZE_W{1'b1}} : v[SIZE_W-1:0];
    endfunction

endpackage

@@ hdl/best_fit_slice_allocator.sv @@
// Top level: sequencer of the best-fit band allocator with glyph shelf packing.
//
// Input channel i_in_*: one item (op, req_height, band_pos, glyph_width) is
// transferred when i_in_valid is high and o_in_stall is low. Output channel
// o_out_*: one result (status, slice_pos, glyph_x, glyph_y) per item,
// transferred when o_out_valid is high and i_out_stall is low.
// Configuration: i_cfg_index 0 writes atlas_width, 1 writes atlas_height;
// o_cfg_ready is always high. Write only while the block is idle.
// Work per item depends on the op: an allocate that is not too tall scans all N
// bands in the table and, on a grant, compacts the entries after the chosen one;
// the band table gives one registered read per cycle, once per entry while
// scanning and once per later entry while compacting.
// One item is in work at a time; o_in_stall is high from the transfer until
// the result is loaded into the output register, so a new item is taken at the
// earliest in the cycle after that. The output register holds one finished
// result so the next item may start while it waits.
// Reset (synchronous, active low) sets both atlas dimensions to 1024; after
// release the sequencer first writes the initial full-height band, with
// o_in_stall high while it does so. A stalled result holds unchanged,
// and the sequencer waits in its last step until the register frees up.
module best_fit_slice_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  bfsa_pkg::t_in                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output bfsa_pkg::t_out               o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [bfsa_pkg::SIZE_W-1:0]  i_cfg_data
);
    import bfsa_pkg::*;

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_atlas_w, r_atlas_h;
    logic [SIZE_W-1:0] r_req, n_req;
    logic [POS_W-1:0]  r_bpos, n_bpos;
    logic [SIZE_W-1:0] r_gw, n_gw;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SIZE_W-1:0] r_cx, n_cx, r_cy, n_cy, r_rm, n_rm;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pend_idx, n_pend_idx;
    logic              r_found, n_found;
    logic [SIZE_W-1:0] r_best_diff, n_best_diff;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic [POS_W-1:0]  r_best_top, n_best_top;
    logic [SIZE_W-1:0] r_px, n_px, r_py, n_py, r_pm, n_pm;
    t_out              r_res, n_res;
    t_out              r_out, n_out;
    logic              r_out_vld, n_out_vld;

    logic              in_xfer;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wr_addr;
    t_band             mem_wr_data;
    logic [IDX_W-1:0]  mem_rd_addr;
    t_band             mem_rd_data;
    t_alu_op           alu_op;
    logic [SIZE_W-1:0] alu_a, alu_b;
    logic [SIZE_W:0]   alu_res;

    bfsa_band_mem u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    bfsa_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w <= ATLAS_RST;
            r_atlas_h <= ATLAS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_WIDTH) begin
                r_atlas_w <= i_cfg_data;
            end else begin
                r_atlas_h <= i_cfg_data;
            end
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_count   <= CNT_W'(1);
            r_cx      <= '0;
            r_cy      <= '0;
            r_rm      <= '0;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_rm      <= n_rm;
            r_out_vld <= n_out_vld;
            r_pend    <= n_pend;
            r_found   <= n_found;
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_bpos      <= n_bpos;
        r_gw        <= n_gw;
        r_idx       <= n_idx;
        r_pend_idx  <= n_pend_idx;
        r_best_diff <= n_best_diff;
        r_best_idx  <= n_best_idx;
        r_best_top  <= n_best_top;
        r_px        <= n_px;
        r_py        <= n_py;
        r_pm        <= n_pm;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // Sequencer: next state, memory and adder control
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_bpos      = r_bpos;
        n_gw        = r_gw;
        n_count     = r_count;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_rm        = r_rm;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_found     = r_found;
        n_best_diff = r_best_diff;
        n_best_idx  = r_best_idx;
        n_best_top  = r_best_top;
        n_px        = r_px;
        n_py        = r_py;
        n_pm        = r_pm;
        n_res       = r_res;
        n_out       = r_out;
        n_out_vld   = r_out_vld;
        mem_we      = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        mem_rd_addr = r_idx[IDX_W-1:0];
        alu_op      = ALU_ADD;
        alu_a       = '0;
        alu_b       = '0;

        // Drain the output register
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                // Write the initial full-height band
                mem_we      = 1'b1;
                mem_wr_addr = '0;
                mem_wr_data = '{top: '0, size: ATLAS_RST};
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_req  = i_in_data.req_height;
                    n_bpos = i_in_data.band_pos;
                    n_gw   = i_in_data.glyph_width;
                    n_res  = '0;
                    case (i_in_data.op)
                        OP_ALLOC: n_state = S_CHECK;
                        OP_FREE:  n_state = S_FREE;
                        OP_PLACE: n_state = S_PWRAP;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_CHECK: begin
                // Reject requests taller than the atlas, then arm the scan
                alu_op      = ALU_SUB;
                alu_a       = r_atlas_h;
                alu_b       = r_req;
                n_idx       = '0;
                n_pend      = 1'b0;
                n_found     = 1'b0;
                n_best_diff = r_atlas_h;
                if (alu_res[SIZE_W]) begin
                    n_res.status = ST_TOO_TALL;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Read one entry per cycle, evaluate the previous read
                alu_op = ALU_SUB;
                alu_a  = mem_rd_data.size;
                alu_b  = r_req;
                if (r_pend && !alu_res[SIZE_W] &&
                    (alu_res[SIZE_W-1:0] < r_best_diff)) begin
                    n_best_diff = alu_res[SIZE_W-1:0];
                    n_best_idx  = r_pend_idx;
                    n_best_top  = mem_rd_data.top;
                    n_found     = 1'b1;
                end
                n_pend     = (r_idx < r_count);
                n_pend_idx = r_idx[IDX_W-1:0];
                if (r_idx < r_count) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (!r_pend && !(r_idx < r_count)) begin
                    n_pend = 1'b0;
                    if (r_found) begin
                        n_idx   = CNT_W'(r_best_idx) + CNT_W'(1);
                        n_state = S_SHIFT;
                    end else begin
                        n_res.status = ST_NO_FIT;
                        n_state      = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                // Move each later entry down by one, keeping order
                if (r_pend) begin
                    mem_we      = 1'b1;
                    mem_wr_addr = r_pend_idx;
                    mem_wr_data = mem_rd_data;
                end
                n_pend     = (r_idx < r_count);
                n_pend_idx = IDX_W'(r_idx - CNT_W'(1));
                if (r_idx < r_count) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (!r_pend && !(r_idx < r_count)) begin
                    n_pend  = 1'b0;
                    n_count = r_count - CNT_W'(1);
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                // Append the remainder band, if nonzero, and restart the shelf cursor
                alu_op = ALU_ADD;
                alu_a  = {1'b0, r_best_top};
                alu_b  = r_req;
                if (r_best_diff != '0) begin
                    mem_we      = 1'b1;
                    mem_wr_addr = r_count[IDX_W-1:0];
                    mem_wr_data = '{top: alu_res[POS_W-1:0], size: r_best_diff};
                    n_count     = r_count + CNT_W'(1);
                end
                n_cx            = '0;
                n_cy            = {1'b0, r_best_top};
                n_rm            = '0;
                n_res.status    = ST_OK;
                n_res.slice_pos = r_best_top;
                n_state         = S_DONE;
            end
            S_FREE: begin
                // Append the freed band unless the table is full
                if (r_count >= CNT_W'(MAX_BANDS)) begin
                    n_res.status = ST_FULL;
                end else begin
                    mem_we      = 1'b1;
                    mem_wr_addr = r_count[IDX_W-1:0];
                    mem_wr_data = '{top: r_bpos, size: r_req};
                    n_count     = r_count + CNT_W'(1);
                end
                n_state = S_DONE;
            end
            S_PWRAP: begin
                // Test the right edge
                alu_op = ALU_ADD;
                alu_a  = r_cx;
                alu_b  = r_gw;
                n_px   = r_cx;
                n_py   = r_cy;
                n_pm   = r_rm;
                if (alu_res >= {1'b0, r_atlas_w}) begin
                    n_px    = '0;
                    n_state = S_PBUMP;
                end else begin
                    n_state = S_PFIT;
                end
            end
            S_PBUMP: begin
                // Open a new shelf below the tallest glyph
                alu_op  = ALU_ADD1;
                alu_a   = r_py;
                alu_b   = r_pm;
                n_py    = sat13(alu_res);
                n_pm    = '0;
                n_state = S_PFIT;
            end
            S_PFIT: begin
                // Test the bottom edge
                alu_op        = ALU_ADD;
                alu_a         = r_py;
                alu_b         = r_req;
                n_res.glyph_x = r_px[POS_W-1:0];
                n_res.glyph_y = r_py[POS_W-1:0];
                if (alu_res > {1'b0, r_atlas_h}) begin
                    n_res.status = ST_GLYPH_OOR;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_PCOMMIT;
                end
            end
            S_PCOMMIT: begin
                // Advance the cursor past the glyph
                alu_op       = ALU_ADD1;
                alu_a        = r_px;
                alu_b        = r_gw;
                n_cx         = sat13(alu_res);
                n_cy         = r_py;
                n_rm         = (r_req > r_pm) ? r_req : r_pm;
                n_res.status = ST_OK;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // Load the output register once it is free
                if (!r_out_vld || !i_out_stall) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // Band count never exceeds the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BANDS))
        else $error("band count above table depth");

    // An accepted item keeps the input stalled in the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input not stalled after transfer");

    // Compaction never writes the entry it is reading
    a_shift_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && mem_we) |-> (mem_wr_addr != mem_rd_addr))
        else $error("compaction read and write collide");

    // A result stalled at the output is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");
`endif

endmodule

@@ hdl/bfsa_band_mem.sv @@
// Free band table memory: one write port, one registered read port.
module bfsa_band_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [bfsa_pkg::IDX_W-1:0]  i_wr_addr,
    input  bfsa_pkg::t_band             i_wr_data,
    input  logic [bfsa_pkg::IDX_W-1:0]  i_rd_addr,
    output bfsa_pkg::t_band             o_rd_data
);
    import bfsa_pkg::*;

    t_band r_mem [MAX_BANDS];
    t_band r_rd_data;

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Register read data
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/bfsa_alu.sv @@
// Shared 13-bit adder/subtractor used by the check, scan, append and placement steps.
module bfsa_alu (
    input  bfsa_pkg::t_alu_op             i_op,
    input  logic [bfsa_pkg::SIZE_W-1:0]   i_a,
    input  logic [bfsa_pkg::SIZE_W-1:0]   i_b,
    output logic [bfsa_pkg::SIZE_W:0]     o_res
);
    import bfsa_pkg::*;

    // Add, add with carry in, or subtract with borrow in the top bit
    always_comb begin
        case (i_op)
            ALU_ADD:  o_res = {1'b0, i_a} + {1'b0, i_b};
            ALU_ADD1: o_res = {1'b0, i_a} + {1'b0, i_b} + (SIZE_W+1)'(1);
            ALU_SUB:  o_res = {1'b0, i_a} - {1'b0, i_b};
            default:  o_res = '0;
        endcase
    end

endmodule

@@ dv/best_fit_slice_allocator_test.sv @@
// Self-checking testbench of the best-fit band allocator: directed table, then randomized phases.
module best_fit_slice_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bfsa_pkg::*;

    // Op code the block ignores
    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         DIRECTED_ROWS   = 21;
    localparam int         NUM_PHASES      = 7;
    localparam int         ITEMS_PER_PHASE = 140;
    // Receiver hold-off: starts after this many input transfers, lasts this many cycles
    localparam int         HOLD_AT         = 350;
    localparam int         HOLD_CYCLES     = 300;
    // Watchdog: cycles without any transfer
    localparam int         IDLE_LIMIT      = 3000;
    localparam int         DRAIN_CYCLES    = 60;
    localparam int         MAX13           = 8191;
    localparam t_out       RESULT_NONE     = '0;

    typedef struct {
        t_in  item;
        int   reps;
        bit   fixed;
        t_out want;
    } t_plan_row;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in               in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out              out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = CFG_WIDTH;
    logic [SIZE_W-1:0] cfg_data  = '0;

    best_fit_slice_allocator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Predictor copy of registers and state, at reset values
    logic [SIZE_W-1:0] atlas_w = ATLAS_RST;
    logic [SIZE_W-1:0] atlas_h = ATLAS_RST;
    logic [POS_W-1:0]  free_top  [MAX_BANDS] = '{default: '0};
    logic [SIZE_W-1:0] free_size [MAX_BANDS] = '{0: ATLAS_RST, default: '0};
    int                free_count = 1;
    logic [SIZE_W-1:0] shelf_x   = '0;
    logic [SIZE_W-1:0] shelf_y   = '0;
    logic [SIZE_W-1:0] shelf_row = '0;

    t_out outcomes_due [$];
    int   errors          = 0;
    int   items_accepted  = 0;
    int   results_checked = 0;
    int   status_seen [8] = '{default: 0};
    bit   no_idle         = 1'b0;

    // Directed table: extremes, every op, and each corner case.
    // Rows with fixed set carry their result; the rest take the predictor's, and all advance it.
    t_plan_row directed_plan [DIRECTED_ROWS] = '{
        // first glyph at the origin
        '{'{OP_PLACE,  13'd5,    12'd0,     13'd10},   1, 1'b1, '{ST_OK, 12'd0, 12'd0, 12'd0}},
        // glyph reaching the right edge wraps to a new shelf
        '{'{OP_PLACE,  13'd3,    12'd0,     13'd1013}, 1, 1'b0, RESULT_NONE},
        // glyph running off the bottom
        '{'{OP_PLACE,  13'd1019, 12'd0,     13'd0},    1, 1'b0, RESULT_NONE},
        // requests taller than the atlas
        '{'{OP_ALLOC,  13'd1025, 12'd0,     13'd0},    1, 1'b1, '{ST_TOO_TALL, 12'd0, 12'd0, 12'd0}},
        '{'{OP_ALLOC,  13'd8191, 12'd4095,  13'd8191}, 1, 1'b1, '{ST_TOO_TALL, 12'd0, 12'd0, 12'd0}},
        // take the whole initial band, then allocate from an empty table
        '{'{OP_ALLOC,  13'd1024, 12'd0,     13'd0},    1, 1'b1, '{ST_OK, 12'd0, 12'd0, 12'd0}},
        '{'{OP_ALLOC,  13'd0,    12'd0,     13'd0},    1, 1'b1, '{ST_NO_FIT, 12'd0, 12'd0, 12'd0}},
        // unused op with every field at its top value
        '{'{OP_UNUSED, 13'd8191, 12'd4095,  13'd8191}, 1, 1'b1, RESULT_NONE},
        // a huge band whose leftover is never below the atlas height
        '{'{OP_FREE,   13'd8191, 12'd4095,  13'd0},    1, 1'b1, RESULT_NONE},
        '{'{OP_ALLOC,  13'd1,    12'd0,     13'd0},    1, 1'b1, '{ST_NO_FIT, 12'd0, 12'd0, 12'd0}},
        '{'{OP_FREE,   13'd200,  12'd100,   13'd0},    1, 1'b1, RESULT_NONE},
        '{'{OP_FREE,   13'd0,    12'd0,     13'd0},    1, 1'b1, RESULT_NONE},
        // exact fit on a zero-height band, then a split with a remainder
        '{'{OP_ALLOC,  13'd0,    12'd0,     13'd0},    1, 1'b0, RESULT_NONE},
        '{'{OP_ALLOC,  13'd150,  12'd0,     13'd0},    1, 1'b0, RESULT_NONE},
        '{'{OP_PLACE,  13'd1,    12'd0,     13'd4096}, 1, 1'b0, RESULT_NONE},
        // fill the table, then one free too many
        '{'{OP_FREE,   13'h0AAA, 12'h555,   13'h1555}, 14, 1'b0, RESULT_NONE},
        '{'{OP_FREE,   13'd7,    12'd7,     13'd0},    1, 1'b0, RESULT_NONE},
        '{'{OP_ALLOC,  13'd50,   12'd0,     13'd0},    1, 1'b0, RESULT_NONE},
        '{'{OP_FREE,   13'h1555, 12'hAAA,   13'd0},    1, 1'b0, RESULT_NONE},
        '{'{OP_PLACE,  13'h0AAA, 12'd0,     13'h1555}, 1, 1'b0, RESULT_NONE},
        '{'{OP_PLACE,  13'd2,    12'd0,     13'd0},    1, 1'b0, RESULT_NONE}
    };

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int clamp13(input int v);
        return (v > MAX13) ? MAX13 : v;
    endfunction

    // Expected result of one item; advances the predictor state
    function automatic t_out atlas_outcome(input t_in item);
        t_out res;
        int   req, best, best_diff, top, sz, x, y, m, w, i;
        bit   found;
        res = RESULT_NONE;
        req = int'(item.req_height);
        case (item.op)
            OP_ALLOC: begin
                if (req > int'(atlas_h)) begin
                    res.status = ST_TOO_TALL;
                end else begin
                    // first band with the smallest leftover below the atlas height
                    best_diff = int'(atlas_h);
                    best = 0;
                    found = 1'b0;
                    for (i = 0; i < free_count; i++) begin
                        sz = int'(free_size[i]);
                        if (sz >= req && sz - req < best_diff) begin
                            best_diff = sz - req;
                            best = i;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        res.status = ST_NO_FIT;
                    end else begin
                        top = int'(free_top[best]);
                        sz = int'(free_size[best]);
                        // drop the band, keep the order, append the remainder
                        for (i = best; i + 1 < free_count; i++) begin
                            free_top[i] = free_top[i+1];
                            free_size[i] = free_size[i+1];
                        end
                        free_count--;
                        if (sz > req) begin
                            free_top[free_count] = POS_W'(top + req);
                            free_size[free_count] = SIZE_W'(sz - req);
                            free_count++;
                        end
                        res.slice_pos = POS_W'(top);
                        shelf_x = '0;
                        shelf_y = SIZE_W'(top);
                        shelf_row = '0;
                    end
                end
            end
            OP_FREE: begin
                if (free_count >= MAX_BANDS) begin
                    res.status = ST_FULL;
                end else begin
                    free_top[free_count] = item.band_pos;
                    free_size[free_count] = item.req_height;
                    free_count++;
                end
            end
            OP_PLACE: begin
                x = int'(shelf_x);
                y = int'(shelf_y);
                m = int'(shelf_row);
                w = int'(item.glyph_width);
                // wrap to a new shelf below the tallest glyph so far
                if (x + w >= int'(atlas_w)) begin
                    x = 0;
                    y = clamp13(y + m + 1);
                    m = 0;
                end
                res.glyph_x = POS_W'(x);
                res.glyph_y = POS_W'(y);
                if (y + req > int'(atlas_h)) begin
                    res.status = ST_GLYPH_OOR;
                end else begin
                    if (req > m) m = req;
                    shelf_x = SIZE_W'(clamp13(x + w + 1));
                    shelf_y = SIZE_W'(y);
                    shelf_row = SIZE_W'(m);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly sensible items sized to the current atlas, with some raw noise
    function automatic t_in random_item();
        t_in it;
        int  aw, ah, roll;
        aw = int'(atlas_w);
        ah = int'(atlas_h);
        roll = int'($urandom_range(0, 99));
        it.op = OP_PLACE;
        it.req_height = SIZE_W'($urandom);
        it.band_pos = POS_W'($urandom);
        it.glyph_width = SIZE_W'($urandom);
        if (roll < 6) begin
            it.op = 2'($urandom);
        end else if (roll < 38) begin
            it.op = OP_PLACE;
            if ($urandom_range(0, 9) != 0) begin
                it.glyph_width = SIZE_W'($urandom_range(0, aw / 3 + 1));
                it.req_height = SIZE_W'($urandom_range(0, ah / 6 + 1));
            end
        end else if (roll < 64) begin
            it.op = OP_ALLOC;
            if ($urandom_range(0, 7) != 0) it.req_height = SIZE_W'($urandom_range(0, ah));
        end else begin
            it.op = OP_FREE;
            if ($urandom_range(0, 7) != 0) begin
                it.req_height = SIZE_W'($urandom_range(1, ah / 3 + 1));
                it.band_pos = POS_W'($urandom_range(0, ah - 1));
            end
        end
        return it;
    endfunction

    // Idle cycles before the next input: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = int'($urandom_range(0, 99));
        if (roll < 55) return 0;
        if (roll < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // Offer one item, hold it until transfer, then queue its expected result
    task automatic offer(input t_in item, input int gap, input bit fixed, input t_out want);
        t_out predicted;
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        items_accepted++;
        predicted = atlas_outcome(item);
        if (fixed) predicted = want;
        outcomes_due = {outcomes_due, predicted};
    endtask

    // Stop offering and wait until every expected result has arrived
    task automatic settle(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_index, input logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        if (reg_index == CFG_WIDTH) atlas_w = value;
        else atlas_h = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus: reset, directed table, then one random phase per atlas setting
    initial begin : stimulus
        int phase_w [NUM_PHASES];
        int phase_h [NUM_PHASES];
        int r, k, p, n;
        phase_w = '{1, 4096, 0, 8191, 4096, 1, 0};
        phase_h = '{1, 4096, 0, 8191, 1, 4096, 0};
        phase_w[2] = int'($urandom_range(16, 200));
        phase_h[2] = int'($urandom_range(32, 600));
        phase_w[6] = int'($urandom_range(64, 1500));
        phase_h[6] = int'($urandom_range(64, 1500));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            for (k = 0; k < directed_plan[r].reps; k++) begin
                offer(directed_plan[r].item, pick_gap(), directed_plan[r].fixed,
                      directed_plan[r].want);
            end
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            settle(4);
            write_reg(CFG_WIDTH, SIZE_W'(phase_w[p]));
            write_reg(CFG_HEIGHT, SIZE_W'(phase_h[p]));
            // last phase runs back to back on both sides
            no_idle = (p == NUM_PHASES - 1);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                offer(random_item(), pick_gap(), 1'b0, RESULT_NONE);
            end
        end

        settle(DRAIN_CYCLES);
        $display("Covered %0d items: directed table, then %0d atlas settings %s; %0d checked",
                 items_accepted, NUM_PHASES, "incl. extremes", results_checked);
        $display("Statuses: ok %0d, too tall %0d, no fit %0d, table full %0d, glyph off atlas %0d",
                 status_seen[int'(ST_OK)], status_seen[int'(ST_TOO_TALL)],
                 status_seen[int'(ST_NO_FIT)], status_seen[int'(ST_FULL)],
                 status_seen[int'(ST_GLYPH_OOR)]);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Result side: random stall runs, one long hold-off, check every transfer
    initial begin : result_sink
        int   run_left, hold_left, roll;
        bit   run_stall, hold_done;
        t_out want, got;
        run_left = 0;
        hold_left = 0;
        run_stall = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && items_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (no_idle) begin
                out_stall <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    roll = int'($urandom_range(0, 99));
                    if (roll < 50) begin
                        run_stall = 1'b0;
                        run_left = int'($urandom_range(1, 30));
                    end else if (roll < 85) begin
                        run_stall = 1'b1;
                        run_left = int'($urandom_range(1, 3));
                    end else begin
                        run_stall = 1'b1;
                        run_left = int'($urandom_range(10, 40));
                    end
                end
                run_left--;
                out_stall <= run_stall;
            end

            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall) begin
                got = out_data;
                results_checked++;
                status_seen[got.status]++;
                if (outcomes_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result status=%0d slice_pos=%0d",
                             $time, got.status, got.slice_pos,
                             " glyph_x=%0d glyph_y=%0d", got.glyph_x, got.glyph_y);
                end else begin
                    want = outcomes_due.pop_front();
                    if (got.status !== want.status || got.slice_pos !== want.slice_pos ||
                        got.glyph_x !== want.glyph_x || got.glyph_y !== want.glyph_y) begin
                        errors++;
                        $display("%0t: mismatch, expected status=%0d slice_pos=%0d",
                                 $time, want.status, want.slice_pos,
                                 " glyph_x=%0d glyph_y=%0d", want.glyph_x, want.glyph_y);
                        $display("%0t:           actual   status=%0d slice_pos=%0d",
                                 $time, got.status, got.slice_pos,
                                 " glyph_x=%0d glyph_y=%0d", got.glyph_x, got.glyph_y);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
                (cfg_valid && cfg_ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= IDLE_LIMIT) begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, quiet);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule

@@ sim.f @@
hdl/bfsa_pkg.sv
hdl/bfsa_band_mem.sv
hdl/bfsa_alu.sv
hdl/best_fit_slice_allocator.sv
dv/best_fit_slice_allocator_test.sv
